>>> hw/rtl/thick_line_span_rasterizer_defines.svh
`ifndef THICK_LINE_SPAN_RASTERIZER_DEFINES_SVH
`define THICK_LINE_SPAN_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tlsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlsr_pkg;

  localparam int COORD_BITS = 16;
  localparam int RADIUS_W   = 5;
  localparam int RADIUS_MAX = 31;
  localparam int MAX_RES    = 63;
  localparam int CNT_W      = 6;
  localparam int SQ_W       = 10;
  localparam int ERR_W      = 18;
  localparam int LEFT_W     = 17;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // r*707/1000 + 1
  localparam logic [RADIUS_W-1:0] IMAX_TBL [32] = '{
    5'd1,  5'd1,  5'd2,  5'd3,  5'd3,  5'd4,  5'd5,  5'd5,
    5'd6,  5'd7,  5'd8,  5'd8,  5'd9,  5'd10, 5'd10, 5'd11,
    5'd12, 5'd13, 5'd13, 5'd14, 5'd15, 5'd15, 5'd16, 5'd17,
    5'd17, 5'd18, 5'd19, 5'd20, 5'd20, 5'd21, 5'd22, 5'd22
  };

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_CHK,
    S_UP,
    S_UN,
    S_DN1,
    S_DN2,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [RADIUS_W-1:0]   brush_radius;
    logic [15:0]           pen_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] span_left;
    logic [COORD_BITS-1:0] span_right;
    logic [COORD_BITS-1:0] span_row;
    logic [15:0]           span_color;
    logic                  span_valid;
    logic                  last_of_step;
    logic                  line_done;
  } out_item_t;

  typedef struct packed {
    logic                  draw;
    logic                  done;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [RADIUS_W-1:0]   radius;
    logic [15:0]           color;
  } step_cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [RADIUS_W-1:0]   half_w;
    logic [RADIUS_W-1:0]   row_off;
    logic                  row_neg;
  } span_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] row;
    logic                  nz;
  } span_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/thick_line_span_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Thick line span rasterizer.
// Input channel in_valid/in_stall/in_data carries load and step items. A load
// stores endpoints, brush radius and color and gives no result.
// A step emits the horizontal spans of the filled brush circle at the current
// line point, then advances the point. Results leave on out_valid/out_stall/
// out_data, one per cycle at most; the last one of a step has last_of_step set.
// A step without spans (inactive line or radius 0) gives one status item.
// Step order: the line state registers the step command and advances the
// line point, then the circle sequencer emits the top span and, for each row
// up to imax = r*707/1000+1, runs a check, an upper cap span pair when the
// check calls for one and two lower spans, then a final state; r=31 gives
// 63 spans. The span unit is shared by all span states. A step with no
// circle goes from idle straight to the final state. in_stall stays high while a
// step is in progress. The result register holds its item while out_stall is
// high; the sequencer waits whenever a new span finds both the hold stage and
// the output full, which adds those stall cycles to the step.
// Synchronous reset clears the line state (no active line) and all pending
// results.

module thick_line_span_rasterizer import tlsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      in_acc;
  logic      cmd_valid;
  step_cmd_t cmd;
  logic      seq_busy;

  assign in_stall = seq_busy || cmd_valid;
  assign in_acc   = in_valid && !in_stall;

  tlsr_line_state u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  tlsr_circle_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .busy      (seq_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tlsr_span_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module tlsr_span_unit import tlsr_pkg::*; (
  input  span_req_t req,
  output span_res_t res
);

  logic [COORD_BITS-1:0] hw_ext;
  logic [COORD_BITS-1:0] ro_ext;

  assign hw_ext = COORD_BITS'(req.half_w);
  assign ro_ext = COORD_BITS'(req.row_off);

  // span of length 2*half_w centered on cx: [cx-half_w, cx+half_w-1]
  always_comb begin
    res.left  = req.cx - hw_ext;
    res.right = req.cx + hw_ext - COORD_BITS'(1);
    res.row   = req.row_neg ? (req.cy - ro_ext) : (req.cy + ro_ext);
    res.nz    = (req.half_w != '0);
  end

endmodule

`default_nettype wire

>>> hw/rtl/tlsr_circle_seq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "thick_line_span_rasterizer_defines.svh"

module tlsr_circle_seq import tlsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  step_cmd_t cmd,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  seq_state_t            state_r, state_nxt;
  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [RADIUS_W-1:0]   r_r, r_nxt;
  logic [15:0]           col_r, col_nxt;
  logic                  done_r, done_nxt;
  logic [RADIUS_W-1:0]   imax_r, imax_nxt;
  logic [SQ_W-1:0]       sqmax_r, sqmax_nxt;
  logic [RADIUS_W-1:0]   i_r, i_nxt;
  logic [RADIUS_W-1:0]   x_r, x_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  held_v_r, held_v_nxt;
  out_item_t             held_r, held_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  span_req_t  sreq;
  span_res_t  sres;
  out_item_t  span_item;
  out_item_t  push_item;
  logic       push;
  logic       span_st;
  logic       gen;
  logic       blocked;
  logic       out_free;
  logic       cond;
  logic       x_big;
  logic [SQ_W:0] sq_sum;

  tlsr_span_unit u_span (
    .req (sreq),
    .res (sres)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign span_st   = (state_r == S_TOP) || (state_r == S_UP) || (state_r == S_UN) ||
                     (state_r == S_DN1) || (state_r == S_DN2);
  assign gen       = span_st && sres.nz && (cnt_r != CNT_W'(MAX_RES));
  assign blocked   = gen && held_v_r && !out_free;
  assign sq_sum    = ({6'b0, i_r} * {6'b0, i_r}) + ({6'b0, x_r} * {6'b0, x_r});
  assign cond      = sq_sum > {1'b0, sqmax_r};
  assign x_big     = x_r > imax_r;

  always_comb begin
    sreq.cx      = cx_r;
    sreq.cy      = cy_r;
    sreq.half_w  = x_r;
    sreq.row_off = i_r;
    sreq.row_neg = 1'b0;
    case (state_r)
      S_TOP: begin
        sreq.half_w  = r_r;
        sreq.row_off = '0;
      end
      S_UP: begin
        sreq.half_w  = i_r - RADIUS_W'(1);
        sreq.row_off = x_r;
      end
      S_UN: begin
        sreq.half_w  = i_r - RADIUS_W'(1);
        sreq.row_off = x_r;
        sreq.row_neg = 1'b1;
      end
      S_DN2: begin
        sreq.row_neg = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    span_item.span_left    = sres.left;
    span_item.span_right   = sres.right;
    span_item.span_row     = sres.row;
    span_item.span_color   = col_r;
    span_item.span_valid   = 1'b1;
    span_item.last_of_step = 1'b0;
    span_item.line_done    = done_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = cmd.draw ? S_TOP : S_FIN;
        end
      end
      S_TOP: begin
        if (!blocked) state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = (cond && x_big) ? S_UP : S_DN1;
      end
      S_UP: begin
        if (!blocked) state_nxt = S_UN;
      end
      S_UN: begin
        if (!blocked) state_nxt = S_DN1;
      end
      S_DN1: begin
        if (!blocked) state_nxt = S_DN2;
      end
      S_DN2: begin
        if (!blocked) state_nxt = (i_r == imax_r) ? S_FIN : S_CHK;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    r_nxt      = r_r;
    col_nxt    = col_r;
    done_nxt   = done_r;
    imax_nxt   = imax_r;
    sqmax_nxt  = sqmax_r;
    i_nxt      = i_r;
    x_nxt      = x_r;
    cnt_nxt    = cnt_r;
    held_v_nxt = held_v_r;
    held_nxt   = held_r;
    push       = 1'b0;
    push_item  = held_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cx_nxt     = cmd.cx;
          cy_nxt     = cmd.cy;
          r_nxt      = cmd.radius;
          col_nxt    = cmd.color;
          done_nxt   = cmd.done;
          imax_nxt   = IMAX_TBL[cmd.radius];
          sqmax_nxt  = (SQ_W'(cmd.radius) * SQ_W'(cmd.radius)) +
                       SQ_W'(cmd.radius >> 1);
          i_nxt      = RADIUS_W'(1);
          x_nxt      = cmd.radius;
          cnt_nxt    = '0;
          held_v_nxt = 1'b0;
        end
      end
      S_CHK: begin
        if (cond && !x_big && (x_r != '0)) x_nxt = x_r - RADIUS_W'(1);
      end
      S_FIN: begin
        if (out_free) begin
          push       = 1'b1;
          held_v_nxt = 1'b0;
          if (held_v_r) begin
            push_item              = held_r;
            push_item.last_of_step = 1'b1;
          end else begin
            push_item              = '0;
            push_item.last_of_step = 1'b1;
            push_item.line_done    = done_r;
          end
        end
      end
      default: begin
      end
    endcase

    if (span_st && !blocked) begin
      if (gen) begin
        held_nxt   = span_item;
        held_v_nxt = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (held_v_r) begin
          push      = 1'b1;
          push_item = held_r;
        end
      end
      if (state_r == S_UN) x_nxt = x_r - RADIUS_W'(1);
      if (state_r == S_DN2) i_nxt = i_r + RADIUS_W'(1);
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    r_r     <= r_nxt;
    col_r   <= col_nxt;
    done_r  <= done_nxt;
    imax_r  <= imax_nxt;
    sqmax_r <= sqmax_nxt;
    i_r     <= i_nxt;
    x_r     <= x_nxt;
    held_r  <= held_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TLSR_ASSERT_NOW(a_idle_no_held, state_r == S_IDLE, !held_v_r, "held span left in idle")
  `TLSR_ASSERT_NOW(a_held_counted, held_v_r, cnt_r != '0, "held span without count")
  `TLSR_ASSERT_NOW(a_x_bound, span_st || state_r == S_CHK, x_r <= r_r, "x above radius")
  `TLSR_ASSERT_NOW(a_i_bound, span_st || state_r == S_CHK, i_r <= imax_r, "i past imax")
  `TLSR_ASSERT_NEXT(a_fin_exit, state_r == S_FIN && out_free, state_r == S_IDLE && out_valid_r && out_r.last_of_step, "step not closed")

endmodule

`default_nettype wire

>>> hw/rtl/tlsr_line_state.sv
`timescale 1ns / 1ps
`default_nettype none

module tlsr_line_state import tlsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_acc,
  input  in_item_t  in_item,
  output logic      cmd_valid,
  output step_cmd_t cmd
);

  logic                  active_r, active_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt;
  logic [COORD_BITS-1:0] py_r, py_nxt;
  logic [ERR_W-1:0]      ex_r, ex_nxt;
  logic [ERR_W-1:0]      ey_r, ey_nxt;
  logic [COORD_BITS-1:0] dx_r, dx_nxt;
  logic [COORD_BITS-1:0] dy_r, dy_nxt;
  logic [COORD_BITS-1:0] major_r, major_nxt;
  dir_t                  xdir_r, xdir_nxt;
  dir_t                  ydir_r, ydir_nxt;
  logic [LEFT_W-1:0]     left_r, left_nxt;
  logic [RADIUS_W-1:0]   radius_r, radius_nxt;
  logic [15:0]           color_r, color_nxt;
  logic                  cmd_valid_r, cmd_valid_nxt;
  step_cmd_t             cmd_r, cmd_nxt;

  logic [COORD_BITS:0]   ddx, ddy;
  logic [COORD_BITS-1:0] ldx, ldy, lmajor;
  dir_t                  lxdir, lydir;
  logic [COORD_BITS-1:0] rad_ext;
  logic                  reject;
  logic [ERR_W-1:0]      sum_x, sum_y, maj_ext;
  logic                  hit_x, hit_y;
  logic [LEFT_W-1:0]     left_dec;

  function automatic logic [COORD_BITS-1:0] move(input logic [COORD_BITS-1:0] p,
                                                 input dir_t d);
    logic [COORD_BITS-1:0] q;
    case (d)
      DIR_INC: q = p + COORD_BITS'(1);
      DIR_DEC: q = p - COORD_BITS'(1);
      default: q = p;
    endcase
    return q;
  endfunction

  always_comb begin
    ddx = {1'b0, in_item.end_x} - {1'b0, in_item.start_x};
    ddy = {1'b0, in_item.end_y} - {1'b0, in_item.start_y};
    if (ddx[COORD_BITS]) begin
      ldx   = in_item.start_x - in_item.end_x;
      lxdir = DIR_DEC;
    end else begin
      ldx   = ddx[COORD_BITS-1:0];
      lxdir = (ddx == '0) ? DIR_NONE : DIR_INC;
    end
    if (ddy[COORD_BITS]) begin
      ldy   = in_item.start_y - in_item.end_y;
      lydir = DIR_DEC;
    end else begin
      ldy   = ddy[COORD_BITS-1:0];
      lydir = (ddy == '0) ? DIR_NONE : DIR_INC;
    end
    lmajor  = (ldx > ldy) ? ldx : ldy;
    rad_ext = COORD_BITS'(in_item.brush_radius);
    reject  = (in_item.start_x < rad_ext) || (in_item.end_x < rad_ext) ||
              (in_item.start_y < rad_ext) || (in_item.end_y < rad_ext);
  end

  always_comb begin
    maj_ext  = ERR_W'(major_r);
    sum_x    = ex_r + ERR_W'(dx_r);
    sum_y    = ey_r + ERR_W'(dy_r);
    hit_x    = sum_x > maj_ext;
    hit_y    = sum_y > maj_ext;
    left_dec = (left_r != '0) ? (left_r - LEFT_W'(1)) : '0;
  end

  always_comb begin
    active_nxt    = active_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    major_nxt     = major_r;
    xdir_nxt      = xdir_r;
    ydir_nxt      = ydir_r;
    left_nxt      = left_r;
    radius_nxt    = radius_r;
    color_nxt     = color_r;
    cmd_valid_nxt = 1'b0;
    cmd_nxt       = cmd_r;
    if (in_acc) begin
      if (in_item.req_type == REQ_LOAD) begin
        radius_nxt = in_item.brush_radius;
        color_nxt  = in_item.pen_color;
        px_nxt     = in_item.start_x;
        py_nxt     = in_item.start_y;
        ex_nxt     = '0;
        ey_nxt     = '0;
        dx_nxt     = ldx;
        dy_nxt     = ldy;
        xdir_nxt   = lxdir;
        ydir_nxt   = lydir;
        major_nxt  = lmajor;
        active_nxt = !reject;
        left_nxt   = reject ? '0 : (LEFT_W'(lmajor) + LEFT_W'(2));
      end else begin
        cmd_valid_nxt = 1'b1;
        cmd_nxt.cx     = px_r;
        cmd_nxt.cy     = py_r;
        cmd_nxt.radius = radius_r;
        cmd_nxt.color  = color_r;
        cmd_nxt.draw   = active_r && (radius_r != '0);
        cmd_nxt.done   = 1'b1;
        if (active_r) begin
          ex_nxt = hit_x ? (sum_x - maj_ext) : sum_x;
          ey_nxt = hit_y ? (sum_y - maj_ext) : sum_y;
          if (hit_x) px_nxt = move(px_r, xdir_r);
          if (hit_y) py_nxt = move(py_r, ydir_r);
          left_nxt     = left_dec;
          active_nxt   = (left_dec != '0);
          cmd_nxt.done = (left_dec == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      ex_r        <= '0;
      ey_r        <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      major_r     <= '0;
      xdir_r      <= DIR_NONE;
      ydir_r      <= DIR_NONE;
      left_r      <= '0;
      radius_r    <= '0;
      color_r     <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      ex_r        <= ex_nxt;
      ey_r        <= ey_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      major_r     <= major_nxt;
      xdir_r      <= xdir_nxt;
      ydir_r      <= ydir_nxt;
      left_r      <= left_nxt;
      radius_r    <= radius_nxt;
      color_r     <= color_nxt;
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire
